// ===== rtl/breakpoint_address_table_defines.svh =====
// Assertion macros for the breakpoint address table checker.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef BREAKPOINT_ADDRESS_TABLE_DEFINES_SVH
`define BREAKPOINT_ADDRESS_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BAT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bat_pkg.sv =====
// Shared types and codes for the breakpoint address table.
// No dependencies; imported by every module of the block.
package bat_pkg;

    localparam int ADDR_W = 64;
    localparam int NUM_W  = 16;

    localparam logic [2:0] OP_CHECK     = 3'd0;
    localparam logic [2:0] OP_ADD       = 3'd1;
    localparam logic [2:0] OP_DEL_ADDR  = 3'd2;
    localparam logic [2:0] OP_DEL_NUM   = 3'd3;
    localparam logic [2:0] OP_DEL_ALL   = 3'd4;
    localparam logic [2:0] OP_CLR_LAST  = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic [NUM_W-1:0]  bp_number;
    } cmd_t;

    typedef struct packed {
        logic              hit;
        logic [1:0]        status;
        logic [NUM_W-1:0]  assigned_number;
        logic [ADDR_W-1:0] last_hit_address;
        logic              last_hit_valid;
    } result_t;

    // Summary flags from the compare lanes.
    typedef struct packed {
        logic addr_found;
        logic free_found;
        logic num_found;
    } match_flags_t;

endpackage

// ===== rtl/breakpoint_address_table.sv =====
// Top level of the breakpoint address table: input register, table storage,
// operation logic and result register. Depends on bat_pkg and bat_match.
//
// One transaction is accepted in every cycle: busy never rises, so start may
// be held high back to back. An accepted transaction passes through the input
// register (in_valid_reg, cmd_reg) and then the result register, which drives
// result with done high for exactly one cycle; the receiver cannot stall it.
// The compare lanes are combinational: they match the registered command
// against all ENTRIES table slots at once, and the table is updated at the
// same edge that loads the result, so each transaction sees the effect of
// the one before it. enabled_reg is written through cfg_wr_en and
// cfg_wr_data and resets to 1.
module breakpoint_address_table #(
    parameter int ENTRIES        = 16,
    parameter int HIT_COUNT_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bat_pkg::cmd_t    cmd,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    output logic             done,
    output bat_pkg::result_t result
);
    import bat_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                      in_valid_reg;
    cmd_t                      cmd_reg;
    logic                      enabled_reg;
    logic                      done_reg;
    result_t                   result_reg;
    result_t                   result_next;

    logic [ENTRIES-1:0]        entry_valid_reg;
    logic [ENTRIES-1:0]        entry_valid_next;
    logic [ADDR_W-1:0]         entry_address_reg [ENTRIES];
    logic [NUM_W-1:0]          entry_number_reg  [ENTRIES];
    logic [HIT_COUNT_BITS-1:0] entry_hits_reg    [ENTRIES];
    logic [NUM_W-1:0]          next_number_reg;
    logic [NUM_W-1:0]          next_number_next;
    logic [ADDR_W-1:0]         last_address_reg;
    logic [ADDR_W-1:0]         last_address_next;
    logic                      last_valid_reg;
    logic                      last_valid_next;

    match_flags_t              flags;
    logic [IDX_W-1:0]          addr_idx;
    logic [IDX_W-1:0]          free_idx;
    logic [ENTRIES-1:0]        num_match;

    logic                      add_we;
    logic                      hits_we;
    logic [IDX_W-1:0]          wr_idx;
    logic [HIT_COUNT_BITS-1:0] hits_cur;

    assign busy = 1'b0;

    bat_match #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_match (
        .valid     (entry_valid_reg),
        .addr_tbl  (entry_address_reg),
        .num_tbl   (entry_number_reg),
        .key_addr  (cmd_reg.address),
        .key_num   (cmd_reg.bp_number),
        .flags     (flags),
        .addr_idx  (addr_idx),
        .free_idx  (free_idx),
        .num_match (num_match)
    );

    assign hits_cur = entry_hits_reg[addr_idx];

    always_comb
    begin
        entry_valid_next  = entry_valid_reg;
        next_number_next  = next_number_reg;
        last_address_next = last_address_reg;
        last_valid_next   = last_valid_reg;
        add_we            = 1'b0;
        hits_we           = 1'b0;
        wr_idx            = addr_idx;
        result_next       = '0;

        if (in_valid_reg)
        begin
            case (cmd_reg.opcode)
                OP_CHECK:
                begin
                    if (flags.addr_found && enabled_reg)
                    begin
                        hits_we           = (hits_cur != '1);
                        last_address_next = cmd_reg.address;
                        last_valid_next   = 1'b1;
                        result_next.hit   = 1'b1;
                    end
                    else
                    begin
                        result_next.status = STATUS_NOT_FOUND;
                    end
                end
                OP_ADD:
                begin
                    // An existing address is renumbered in place.
                    if (flags.addr_found || flags.free_found)
                    begin
                        wr_idx                      = flags.addr_found ? addr_idx : free_idx;
                        add_we                      = 1'b1;
                        entry_valid_next[wr_idx]    = 1'b1;
                        result_next.assigned_number = next_number_reg;
                        next_number_next            = next_number_reg + 1'b1;
                    end
                    else
                    begin
                        result_next.status = STATUS_FULL;
                    end
                end
                OP_DEL_ADDR:
                begin
                    if (flags.addr_found)
                    begin
                        entry_valid_next[addr_idx] = 1'b0;
                    end
                    else
                    begin
                        result_next.status = STATUS_NOT_FOUND;
                    end
                end
                OP_DEL_NUM:
                begin
                    entry_valid_next = entry_valid_reg & ~num_match;
                    if (!flags.num_found)
                    begin
                        result_next.status = STATUS_NOT_FOUND;
                    end
                end
                OP_DEL_ALL:
                begin
                    entry_valid_next = '0;
                    next_number_next = '0;
                end
                OP_CLR_LAST:
                begin
                    last_address_next = '0;
                    last_valid_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        result_next.last_hit_address = last_address_next;
        result_next.last_hit_valid   = last_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            enabled_reg      <= 1'b1;
            done_reg         <= 1'b0;
            entry_valid_reg  <= '0;
            next_number_reg  <= '0;
            last_address_reg <= '0;
            last_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= start && !busy;
            done_reg         <= in_valid_reg;
            entry_valid_reg  <= entry_valid_next;
            next_number_reg  <= next_number_next;
            last_address_reg <= last_address_next;
            last_valid_reg   <= last_valid_next;
            if (cfg_wr_en)
            begin
                enabled_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        result_reg <= result_next;
        if (add_we)
        begin
            entry_address_reg[wr_idx] <= cmd_reg.address;
            entry_number_reg[wr_idx]  <= next_number_reg;
            entry_hits_reg[wr_idx]    <= '0;
        end
        else if (hits_we)
        begin
            entry_hits_reg[addr_idx] <= hits_cur + 1'b1;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/bat_match.sv =====
// Parallel compare lanes of the breakpoint address table: address match,
// number match and lowest free slot. Depends on bat_pkg.
module bat_match #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic [ENTRIES-1:0]        valid,
    input  logic [bat_pkg::ADDR_W-1:0] addr_tbl [ENTRIES],
    input  logic [bat_pkg::NUM_W-1:0]  num_tbl  [ENTRIES],
    input  logic [bat_pkg::ADDR_W-1:0] key_addr,
    input  logic [bat_pkg::NUM_W-1:0]  key_num,
    output bat_pkg::match_flags_t      flags,
    output logic [IDX_W-1:0]           addr_idx,
    output logic [IDX_W-1:0]           free_idx,
    output logic [ENTRIES-1:0]         num_match
);
    import bat_pkg::*;

    logic [ENTRIES-1:0] addr_match;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            addr_match[i] = valid[i] && (addr_tbl[i] == key_addr);
            num_match[i]  = valid[i] && (num_tbl[i] == key_num);
        end
    end

    // Lowest index wins in both searches, scanned from the top down.
    always_comb
    begin
        addr_idx = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (addr_match[i])
            begin
                addr_idx = IDX_W'(i);
            end
            if (!valid[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign flags.addr_found = |addr_match;
    assign flags.free_found = ~&valid;
    assign flags.num_found  = |num_match;

endmodule

// ===== rtl/bat_checker.sv =====
// Port-level checker for the breakpoint address table, bound to the top level.
// Depends on bat_pkg and breakpoint_address_table_defines.svh.
`include "breakpoint_address_table_defines.svh"

module bat_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input bat_pkg::result_t result
);
    import bat_pkg::*;

    // Every accepted transaction is followed by its result with done.
    `BAT_ASSERT_NEXT(a_result_follows, start && !busy, ##1 done, "accepted transaction lost")

    // A result never appears without an accepted transaction before it.
    `BAT_ASSERT_SAME(a_no_spurious, !$past(start && !busy, 2), !done, "result without transaction")

    // A hit is always reported with status ok and a recorded last hit.
    `BAT_ASSERT_SAME(a_hit_consistent, done && result.hit,
        result.status == STATUS_OK && result.last_hit_valid, "hit with bad status or record")

    // A full table gives no number and no hit.
    `BAT_ASSERT_SAME(a_full_clean, done && result.status == STATUS_FULL,
        result.assigned_number == '0 && !result.hit, "table full result not clean")

endmodule

bind breakpoint_address_table bat_checker u_bat_checker (.*);

// ===== tb/breakpoint_address_table_tb.sv =====
// Self-checking testbench for the breakpoint address table.
// A scoreboard class predicts every result from its own copy of the table.
// Depends on bat_pkg and the breakpoint_address_table RTL.
`timescale 1ns / 100ps

module breakpoint_address_table_tb;
    import bat_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int HIT_BITS      = 32;
    localparam int POOL_SIZE     = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    // The two opcodes that the block decodes as no-ops.
    localparam logic [2:0] OP_RESERVED_LO = 3'd6;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    class bp_table_scoreboard;
        bit                      slot_valid [TABLE_ENTRIES];
        logic [ADDR_W-1:0]       slot_addr  [TABLE_ENTRIES];
        logic [NUM_W-1:0]        slot_num   [TABLE_ENTRIES];
        logic [HIT_BITS-1:0]     slot_hits  [TABLE_ENTRIES];
        logic [NUM_W-1:0]        next_num;
        logic [ADDR_W-1:0]       last_addr;
        bit                      last_vld;
        bit                      enabled;
        result_t                 pending_results [$];
        int                      mismatches;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_valid[i] = 1'b0;
            end
            next_num   = '0;
            last_addr  = '0;
            last_vld   = 1'b0;
            enabled    = 1'b1;
            mismatches = 0;
        endfunction

        function void set_enabled(bit value);
            enabled = value;
        endfunction

        function int find_slot(logic [ADDR_W-1:0] a);
            int slot;
            slot = -1;
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
            begin
                if (slot_valid[i] && slot_addr[i] == a)
                    slot = i;
            end
            return slot;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Applies one accepted transaction to the table copy and queues its result.
        function void note_command(cmd_t c);
            result_t r;
            int      slot;
            bit      found;
            r = '0;
            case (c.opcode)
                OP_CHECK:
                begin
                    slot = find_slot(c.address);
                    if (slot >= 0 && enabled)
                    begin
                        if (slot_hits[slot] != '1)
                            slot_hits[slot] = slot_hits[slot] + 1'b1;
                        last_addr = c.address;
                        last_vld  = 1'b1;
                        r.hit     = 1'b1;
                    end
                    else
                        r.status = STATUS_NOT_FOUND;
                end
                OP_ADD:
                begin
                    slot = find_slot(c.address);
                    for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
                    begin
                        if (!slot_valid[i])
                            slot = i;
                    end
                    if (slot < 0)
                        r.status = STATUS_FULL;
                    else
                    begin
                        slot_valid[slot]  = 1'b1;
                        slot_addr[slot]   = c.address;
                        slot_num[slot]    = next_num;
                        slot_hits[slot]   = '0;
                        r.assigned_number = next_num;
                        next_num          = next_num + 1'b1;
                    end
                end
                OP_DEL_ADDR:
                begin
                    slot = find_slot(c.address);
                    if (slot >= 0)
                        slot_valid[slot] = 1'b0;
                    else
                        r.status = STATUS_NOT_FOUND;
                end
                OP_DEL_NUM:
                begin
                    found = 1'b0;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (slot_valid[i] && slot_num[i] == c.bp_number)
                        begin
                            slot_valid[i] = 1'b0;
                            found         = 1'b1;
                        end
                    end
                    if (!found)
                        r.status = STATUS_NOT_FOUND;
                end
                OP_DEL_ALL:
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        slot_valid[i] = 1'b0;
                    end
                    next_num = '0;
                end
                OP_CLR_LAST:
                begin
                    last_addr = '0;
                    last_vld  = 1'b0;
                end
                default:
                begin
                end
            endcase
            r.last_hit_address = last_addr;
            r.last_hit_valid   = last_vld;
            pending_results.push_back(r);
        endfunction

        function void check_result(result_t act);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result with no transaction outstanding: %h", $realtime, act);
                return;
            end
            exp = pending_results.pop_front();
            if (act.hit !== exp.hit || act.status !== exp.status
                || act.assigned_number !== exp.assigned_number
                || act.last_hit_address !== exp.last_hit_address
                || act.last_hit_valid !== exp.last_hit_valid)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("[%0t] result mismatch", $realtime);
                    $display("    expected hit=%b status=%0d num=%h last=%h last_valid=%b",
                             exp.hit, exp.status, exp.assigned_number,
                             exp.last_hit_address, exp.last_hit_valid);
                    $display("    actual   hit=%b status=%0d num=%h last=%h last_valid=%b",
                             act.hit, act.status, act.assigned_number,
                             act.last_hit_address, act.last_hit_valid);
                end
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    cfg_wr_en;
    logic    cfg_wr_data;
    logic    done;
    result_t result;

    bp_table_scoreboard sb;
    logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];
    int                 idle_pct;
    int                 cycle_count;

    breakpoint_address_table #(
        .ENTRIES        (TABLE_ENTRIES),
        .HIT_COUNT_BITS (HIT_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Results are checked before the new transaction is noted, so an
    // unexpected result cannot be matched against one accepted this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (cfg_wr_en)
                sb.set_enabled(cfg_wr_data);
            if (start && !busy)
                sb.note_command(cmd);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue(input cmd_t c);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            cmd   <= {3'($urandom), $urandom, $urandom, NUM_W'($urandom)};
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic issue_op(input logic [2:0] code, input logic [ADDR_W-1:0] a,
                            input logic [NUM_W-1:0] n);
        cmd_t c;
        c.opcode    = code;
        c.address   = a;
        c.bp_number = n;
        issue(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_enable(input bit value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // Most addresses come from a small pool so that checks hit and deletes find.
    function automatic cmd_t random_command();
        cmd_t c;
        int   roll;
        c.address   = ($urandom_range(0, 99) < 88) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : {$urandom, $urandom};
        c.bp_number = NUM_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 40)
            c.opcode = OP_CHECK;
        else if (roll < 65)
            c.opcode = OP_ADD;
        else if (roll < 76)
            c.opcode = OP_DEL_ADDR;
        else if (roll < 86)
        begin
            c.opcode = OP_DEL_NUM;
            if ($urandom_range(0, 99) < 75)
                c.bp_number = sb.next_num - NUM_W'($urandom_range(1, 24));
        end
        else if (roll < 88)
            c.opcode = OP_DEL_ALL;
        else if (roll < 95)
            c.opcode = OP_CLR_LAST;
        else
            c.opcode = $urandom_range(0, 1) ? OP_RESERVED_LO : OP_RESERVED_HI;
        return c;
    endfunction

    initial
    begin
        logic [ADDR_W-1:0] all_ones;
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        idle_pct    = 0;
        cycle_count = 0;
        all_ones    = '1;
        addr_pool[0] = '0;
        addr_pool[1] = all_ones;
        addr_pool[2] = {1'b1, {(ADDR_W - 1){1'b0}}};
        for (int i = 3; i < POOL_SIZE; i++)
        begin
            addr_pool[i] = {$urandom, $urandom};
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: extremes, existing-address adds, misses and a full table.
        idle_pct = 10;
        issue_op(OP_CHECK,    64'h1000, 16'h0000);
        issue_op(OP_ADD,      '0,       16'hFFFF);
        issue_op(OP_ADD,      all_ones, 16'h0000);
        issue_op(OP_CHECK,    '0,       16'h0000);
        issue_op(OP_CHECK,    all_ones, 16'hFFFF);
        issue_op(OP_ADD,      '0,       16'h0000);
        issue_op(OP_DEL_NUM,  '0,       16'd2);
        issue_op(OP_DEL_NUM,  '0,       16'd2);
        issue_op(OP_DEL_NUM,  all_ones, 16'hFFFF);
        issue_op(OP_DEL_ADDR, all_ones, 16'h0000);
        issue_op(OP_DEL_ADDR, all_ones, 16'h0000);
        issue_op(OP_CLR_LAST, all_ones, 16'hFFFF);
        issue_op(OP_RESERVED_LO, all_ones, 16'hFFFF);
        issue_op(OP_RESERVED_HI, '0,       16'h0000);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            issue_op(OP_ADD, addr_pool[i + 2], 16'h0000);
        end
        issue_op(OP_ADD,     64'h1000,     16'h0000);
        issue_op(OP_ADD,     addr_pool[5], 16'h0000);
        issue_op(OP_DEL_ALL, addr_pool[5], 16'h0000);
        issue_op(OP_CHECK,   addr_pool[5], 16'h0000);
        drain();

        // Random part in three idle profiles, each split into four chunks, of which
        // the second runs with the enable register cleared. Every chunk starts from a drained block.
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 14 : (phase == 1) ? 58 : 0;
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                drain();
                write_enable(chunk != 1);
                for (int k = 0; k < 115; k++)
                begin
                    issue(random_command());
                end
            end
        end

        drain();
        repeat (8) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
